>>> hw/rtl/cvh_pkg.sv
// Shared types, constants and state encoding for the convex hull block.
`timescale 1ns / 1ps
package cvh_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int PT_W       = 2 * COORD_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [CNT_W-1:0]          t_cnt;

    // Point packed as y in the upper half, x in the lower half
    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_point;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SETUP,
        S_SORT_KEY,
        S_SORT_KEYW,
        S_SORT_TEST,
        S_SORT_GO,
        S_SORT_W1,
        S_SORT_W2,
        S_SORT_DEC,
        S_SORT_PUT,
        S_SCAN_TEST,
        S_SCAN_GO,
        S_SCAN_W1,
        S_SCAN_W2,
        S_SCAN_DEC,
        S_SCAN_PUSH,
        S_OUT_CHK,
        S_OUT_RD,
        S_OUT_EMIT,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic pt_load;
        logic sort_init;
        logic key_rd;
        logic key_cap;
        logic prev_rd;
        logic geo_scan;
        logic shift;
        logic put_key;
        logic scan_init;
        logic scan_rd;
        logic pop;
        logic push;
        logic out_init;
        logic out_rd;
        logic emit;
        logic emit_nh;
        logic finish;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic n_lt3;
        logic i_eq_n;
        logic j_zero;
        logic d_gt1;
        logic d_lt3;
        logic k_last;
        logic ahead;
        logic turn_nonneg;
    } t_dp_stat;

endpackage

>>> hw/rtl/convex_hull_graham_scan.sv
// Top level of the Graham scan convex hull block.
`timescale 1ns / 1ps
// Usage:
//   Points enter one per cycle: an item is taken at a clock edge with start
//   high and busy low, carrying i_x, i_y and i_last. Up to 64 points are kept;
//   further points are dropped and reported through o_overflow.
//   The item with i_last high closes the set and raises busy. The block then
//   sorts the points by angle around the pivot (insertion sort) and runs
//   the stack scan, which skips the turn test while the stack holds fewer
//   than two; every compare goes through one shared three-stage multiply
//   unit and one port of the point memory.
//   Hull vertices then leave clockwise, each after a stack read and each
//   marked by o_valid for one cycle; o_last_vertex flags the final one. With
//   fewer than 3 points or hull vertices one item with o_no_hull high is given.
//   Results cannot be held off: the receiver takes each in its cycle.
//   busy falls in the cycle after the final result strobe.
//   Synchronous reset (i_rst_n low) empties the point set and returns the
//   block to accepting points.
module convex_hull_graham_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cvh_pkg::t_coord i_x,
    input  cvh_pkg::t_coord i_y,
    input  logic            i_last,
    output logic            o_valid,
    output cvh_pkg::t_coord o_hull_x,
    output cvh_pkg::t_coord o_hull_y,
    output logic            o_no_hull,
    output logic            o_overflow,
    output logic            o_last_vertex
);
    import cvh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cvh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    cvh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_hull_x      (o_hull_x),
        .o_hull_y      (o_hull_y),
        .o_no_hull     (o_no_hull),
        .o_overflow    (o_overflow),
        .o_last_vertex (o_last_vertex)
    );

endmodule

>>> hw/rtl/cvh_geom.sv
// Pipelined cross product and squared distance unit, three register stages.
`timescale 1ns / 1ps
module cvh_geom (
    input  logic           i_clk,
    input  cvh_pkg::t_point i_a,
    input  cvh_pkg::t_point i_b,
    input  cvh_pkg::t_point i_c,
    output logic           o_before,
    output logic           o_turn_nonneg
);
    import cvh_pkg::*;

    logic signed [DIFF_W-1:0] r_bx, r_by, r_cx, r_cy;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [SUM_W-1:0]  r_cross, r_da, r_db;

    // Stage one: differences against the origin point
    always_ff @(posedge i_clk) begin
        r_bx <= DIFF_W'(i_b.x) - DIFF_W'(i_a.x);
        r_by <= DIFF_W'(i_b.y) - DIFF_W'(i_a.y);
        r_cx <= DIFF_W'(i_c.x) - DIFF_W'(i_a.x);
        r_cy <= DIFF_W'(i_c.y) - DIFF_W'(i_a.y);
    end

    // Stage two: one multiplier per product
    always_ff @(posedge i_clk) begin
        r_p1 <= r_bx * r_cy;
        r_p2 <= r_by * r_cx;
        r_p3 <= r_bx * r_bx;
        r_p4 <= r_by * r_by;
        r_p5 <= r_cx * r_cx;
        r_p6 <= r_cy * r_cy;
    end

    // Stage three: cross product and distances
    always_ff @(posedge i_clk) begin
        r_cross <= SUM_W'(r_p1) - SUM_W'(r_p2);
        r_da    <= SUM_W'(r_p3) + SUM_W'(r_p4);
        r_db    <= SUM_W'(r_p5) + SUM_W'(r_p6);
    end

    // Order: b before c when c lies clockwise of b, nearer first when collinear
    assign o_before      = (r_cross == '0) ? (r_da < r_db) : r_cross[SUM_W-1];
    assign o_turn_nonneg = ~r_cross[SUM_W-1];

endmodule

>>> hw/rtl/cvh_dp.sv
// Datapath: point and stack memories, sort and scan indexes, result registers.
`timescale 1ns / 1ps
module cvh_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cvh_pkg::t_coord   i_x,
    input  cvh_pkg::t_coord   i_y,
    input  cvh_pkg::t_dp_cmd  i_cmd,
    output cvh_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output cvh_pkg::t_coord   o_hull_x,
    output cvh_pkg::t_coord   o_hull_y,
    output logic              o_no_hull,
    output logic              o_overflow,
    output logic              o_last_vertex
);
    import cvh_pkg::*;

    t_point r_pts [MAX_POINTS];
    t_point r_stk [MAX_POINTS];

    t_cnt   r_count, r_i, r_j, r_d, r_k;
    logic   r_dropped;
    t_point r_pivot, r_key, r_p_rd, r_s_rd0, r_s_rd1;
    t_point in_pt, geo_a, geo_b, pt_wdata;
    logic   pt_we;
    t_cnt   pt_waddr, s_raddr0, j_prev, d_prev;
    logic   geo_ahead, geo_turn_nonneg, new_pivot;

    assign in_pt = '{y: i_y, x: i_x};

    // Lowest y wins, ties to lowest x
    assign new_pivot = (r_count == '0) || (i_y < r_pivot.y) ||
                       ((i_y == r_pivot.y) && (i_x < r_pivot.x));

    // Count, drop flag, stack depth and valid strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_d       <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit | i_cmd.emit_nh;
            if (i_cmd.pt_load) begin
                if (r_count < CNT_W'(MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_d <= '0;
            end else if (i_cmd.pop) begin
                r_d <= r_d - 1'b1;
            end else if (i_cmd.push) begin
                r_d <= r_d + 1'b1;
            end
            if (i_cmd.finish) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_d       <= '0;
            end
        end
    end

    // Pivot, key, and sort, scan and output indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_load && r_count < CNT_W'(MAX_POINTS) && new_pivot) begin
            r_pivot <= in_pt;
        end
        if (i_cmd.key_cap) begin
            r_key <= r_p_rd;
        end
        if (i_cmd.sort_init) begin
            r_i <= CNT_W'(1);
        end else if (i_cmd.scan_init) begin
            r_i <= '0;
        end else if (i_cmd.put_key || i_cmd.push) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.key_rd) begin
            r_j <= r_i;
        end else if (i_cmd.shift) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.out_init) begin
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Point memory write port
    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = r_j;
        pt_wdata = r_key;
        if (i_cmd.pt_load && r_count < CNT_W'(MAX_POINTS)) begin
            pt_we    = 1'b1;
            pt_waddr = r_count;
            pt_wdata = in_pt;
        end else if (i_cmd.shift) begin
            pt_we    = 1'b1;
            pt_wdata = r_p_rd;
        end else if (i_cmd.put_key) begin
            pt_we    = 1'b1;
        end
    end

    assign j_prev = r_j - 1'b1;
    assign d_prev = r_d - 1'b1;

    // Point memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pts[pt_waddr[IDX_W-1:0]] <= pt_wdata;
        end
        if (i_cmd.key_rd || i_cmd.scan_rd) begin
            r_p_rd <= r_pts[r_i[IDX_W-1:0]];
        end else if (i_cmd.prev_rd) begin
            r_p_rd <= r_pts[j_prev[IDX_W-1:0]];
        end
    end

    assign s_raddr0 = i_cmd.out_rd ? r_k : (r_d - CNT_W'(2));

    // Stack memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk[r_d[IDX_W-1:0]] <= r_p_rd;
        end
        if (i_cmd.scan_rd || i_cmd.out_rd) begin
            r_s_rd0 <= r_stk[s_raddr0[IDX_W-1:0]];
            r_s_rd1 <= r_stk[d_prev[IDX_W-1:0]];
        end
    end

    // Select operands for sort compare or scan turn test
    assign geo_a = i_cmd.geo_scan ? r_s_rd0 : r_pivot;
    assign geo_b = i_cmd.geo_scan ? r_s_rd1 : r_key;

    cvh_geom u_geom (
        .i_clk         (i_clk),
        .i_a           (geo_a),
        .i_b           (geo_b),
        .i_c           (r_p_rd),
        .o_before      (geo_ahead),
        .o_turn_nonneg (geo_turn_nonneg)
    );

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_nh) begin
            o_hull_x      <= '0;
            o_hull_y      <= '0;
            o_no_hull     <= 1'b1;
            o_overflow    <= r_dropped;
            o_last_vertex <= 1'b1;
        end else if (i_cmd.emit) begin
            o_hull_x      <= r_s_rd0.x;
            o_hull_y      <= r_s_rd0.y;
            o_no_hull     <= 1'b0;
            o_overflow    <= r_dropped;
            o_last_vertex <= (r_k == r_d - 1'b1);
        end
    end

    assign o_stat = '{
        n_lt3:       (r_count < CNT_W'(3)),
        i_eq_n:      (r_i == r_count),
        j_zero:      (r_j == '0),
        d_gt1:       (r_d > CNT_W'(1)),
        d_lt3:       (r_d < CNT_W'(3)),
        k_last:      (r_k == r_d - 1'b1),
        ahead:       geo_ahead,
        turn_nonneg: geo_turn_nonneg
    };

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");
    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d <= r_count)
        else $error("stack deeper than point count");
    a_nh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_hull |-> o_hull_x == '0 && o_hull_y == '0 && o_last_vertex)
        else $error("no-hull item carries coordinates");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_nh |=> o_valid && o_no_hull)
        else $error("no-hull item not delivered");
`endif

endmodule

>>> hw/rtl/cvh_ctrl.sv
// Controller: sequences load, insertion sort, stack scan and result output.
`timescale 1ns / 1ps
module cvh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_last,
    input  cvh_pkg::t_dp_stat i_stat,
    output cvh_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import cvh_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.pt_load = 1'b1;
                    if (i_last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (i_stat.n_lt3) begin
                    o_cmd.emit_nh = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.sort_init = 1'b1;
                    n_state         = S_SORT_KEY;
                end
            end
            S_SORT_KEY: begin
                if (i_stat.i_eq_n) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_TEST;
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = S_SORT_KEYW;
                end
            end
            S_SORT_KEYW: begin
                o_cmd.key_cap = 1'b1;
                n_state       = S_SORT_TEST;
            end
            S_SORT_TEST: begin
                if (i_stat.j_zero) begin
                    n_state = S_SORT_PUT;
                end else begin
                    o_cmd.prev_rd = 1'b1;
                    n_state       = S_SORT_GO;
                end
            end
            S_SORT_GO: n_state = S_SORT_W1;
            S_SORT_W1: n_state = S_SORT_W2;
            S_SORT_W2: n_state = S_SORT_DEC;
            S_SORT_DEC: begin
                if (i_stat.ahead) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_SORT_TEST;
                end else begin
                    n_state = S_SORT_PUT;
                end
            end
            S_SORT_PUT: begin
                o_cmd.put_key = 1'b1;
                n_state       = S_SORT_KEY;
            end
            S_SCAN_TEST: begin
                if (i_stat.i_eq_n) begin
                    n_state = S_OUT_CHK;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = i_stat.d_gt1 ? S_SCAN_GO : S_SCAN_PUSH;
                end
            end
            S_SCAN_GO: begin
                o_cmd.geo_scan = 1'b1;
                n_state        = S_SCAN_W1;
            end
            S_SCAN_W1: n_state = S_SCAN_W2;
            S_SCAN_W2: n_state = S_SCAN_DEC;
            S_SCAN_DEC: begin
                if (i_stat.turn_nonneg) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_SCAN_TEST;
                end else begin
                    n_state = S_SCAN_PUSH;
                end
            end
            S_SCAN_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_SCAN_TEST;
            end
            S_OUT_CHK: begin
                if (i_stat.d_lt3) begin
                    o_cmd.emit_nh = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.out_init = 1'b1;
                    n_state        = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.k_last ? S_FINISH : S_OUT_RD;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_state != S_LOAD)
        else $error("busy while loading");
    a_finish_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |=> !busy)
        else $error("no return to load after run");
    a_emit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.emit_nh))
        else $error("hull and no-hull item together");
`endif

endmodule

>>> bench/tb_convex_hull_graham_scan.sv
// Self-checking testbench for the Graham scan convex hull block.
`timescale 1ns / 1ps
module tb_convex_hull_graham_scan;
    import cvh_pkg::*;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   nh;
        logic   ovf;
        logic   lastv;
    } t_vertex;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
        logic   chk;     // typed-in result present
        logic   e_nh;
        logic   e_ovf;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_coord i_x = '0;
    t_coord i_y = '0;
    logic   i_last = 1'b0;
    logic   busy, o_valid, o_no_hull, o_overflow, o_last_vertex;
    t_coord o_hull_x, o_hull_y;

    // Predictor state
    t_point pts[MAX_POINTS];
    int     pt_cnt;
    t_point pivot;
    logic   dropped;

    t_vertex hull_queue[$];
    int      fail_cnt;
    int      fed;

    convex_hull_graham_scan i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_x, .i_y, .i_last,
        .o_valid, .o_hull_x, .o_hull_y, .o_no_hull, .o_overflow, .o_last_vertex
    );

    always #6 i_clk = ~i_clk;

    // Sign of (b-a) x (c-a)
    function automatic int cross_sign(t_point a, t_point b, t_point c);
        longint bx, by, cx, cy, v;
        bx = longint'(b.x) - a.x;
        by = longint'(b.y) - a.y;
        cx = longint'(c.x) - a.x;
        cy = longint'(c.y) - a.y;
        v  = bx * cy - by * cx;
        return v < 0 ? -1 : (v > 0 ? 1 : 0);
    endfunction

    function automatic longint dist_sq(t_point a, t_point b);
        longint dx, dy;
        dx = longint'(a.x) - b.x;
        dy = longint'(a.y) - b.y;
        return dx * dx + dy * dy;
    endfunction

    function automatic bit sorts_first(t_point a, t_point b);
        int o;
        o = cross_sign(pivot, a, b);
        if (o == 0) return dist_sq(pivot, a) < dist_sq(pivot, b);
        return o < 0;
    endfunction

    // Absorb one point; on the closing point compute the hull
    task automatic predict_hull(t_coord x, t_coord y, logic last);
        t_point p, key;
        t_vertex v;
        int stk[MAX_POINTS];
        int depth, j;
        p.x = x;
        p.y = y;
        if (pt_cnt < MAX_POINTS) begin
            if (pt_cnt == 0 || p.y < pivot.y || (p.y == pivot.y && p.x < pivot.x))
                pivot = p;
            pts[pt_cnt] = p;
            pt_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!last) return;
        depth = 0;
        if (pt_cnt >= 3) begin
            for (int i = 1; i < pt_cnt; i++) begin
                key = pts[i];
                j = i;
                while (j > 0 && sorts_first(key, pts[j-1])) begin
                    pts[j] = pts[j-1];
                    j--;
                end
                pts[j] = key;
            end
            for (int i = 0; i < pt_cnt; i++) begin
                while (depth > 1 &&
                       cross_sign(pts[stk[depth-2]], pts[stk[depth-1]], pts[i]) >= 0)
                    depth--;
                stk[depth] = i;
                depth++;
            end
        end
        if (pt_cnt < 3 || depth < 3) begin
            v = '{x: '0, y: '0, nh: 1'b1, ovf: dropped, lastv: 1'b1};
            hull_queue = {hull_queue, v};
        end else begin
            for (int i = 0; i < depth; i++) begin
                v = '{x: pts[stk[i]].x, y: pts[stk[i]].y, nh: 1'b0, ovf: dropped,
                      lastv: (i + 1 == depth)};
                hull_queue = {hull_queue, v};
            end
        end
        pt_cnt  = 0;
        dropped = 1'b0;
    endtask

    // Present one point and hold it until taken
    task automatic send_point(t_coord x, t_coord y, logic last, bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 20) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_x    <= x;
        i_y    <= y;
        i_last <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_hull(x, y, last);
        fed++;
    endtask

    // Check each vertex against the oldest expectation
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid) begin
            if (hull_queue.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_hull_x, o_hull_y);
                fail_cnt++;
            end else begin
                e = hull_queue.pop_front();
                if (o_hull_x !== e.x) begin
                    $error("hull_x exp %0d got %0d", e.x, o_hull_x); fail_cnt++;
                end
                if (o_hull_y !== e.y) begin
                    $error("hull_y exp %0d got %0d", e.y, o_hull_y); fail_cnt++;
                end
                if (o_no_hull !== e.nh) begin
                    $error("no_hull exp %0b got %0b", e.nh, o_no_hull); fail_cnt++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow exp %0b got %0b", e.ovf, o_overflow); fail_cnt++;
                end
                if (o_last_vertex !== e.lastv) begin
                    $error("last_vertex exp %0b got %0b", e.lastv, o_last_vertex);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row dir[$];
        t_vertex e;
        int n, mode, r;
        t_coord cx, cy;
        pt_cnt = 0; dropped = 1'b0; pivot = '0; fail_cnt = 0; fed = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: tiny sets, extremes, collinear, duplicates
        dir = '{
            '{16'sd5, 16'sd5, 1'b1, 1'b1, 1'b1, 1'b0},
            '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b1, 1'b0},
            '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd1, 16'sd1, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd2, 16'sd2, 1'b1, 1'b1, 1'b1, 1'b0},
            '{16'sd7, 16'sd7, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd7, 16'sd7, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd7, 16'sd7, 1'b1, 1'b1, 1'b1, 1'b0},
            '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0},
            '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd0, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd32767, -16'sd32768, 1'b1, 1'b0, 1'b0, 1'b0}
        };
        foreach (dir[k]) begin
            if (dir[k].chk) begin
                send_point(dir[k].x, dir[k].y, dir[k].last, 1'b0);
                e = hull_queue[$];
                if (e.nh !== dir[k].e_nh) begin
                    $error("table row %0d: no_hull exp %0b got %0b", k, dir[k].e_nh, e.nh);
                    fail_cnt++;
                end
                if (e.ovf !== dir[k].e_ovf) begin
                    $error("table row %0d: overflow exp %0b got %0b", k, dir[k].e_ovf,
                           e.ovf);
                    fail_cnt++;
                end
            end else begin
                send_point(dir[k].x, dir[k].y, dir[k].last, 1'b0);
            end
        end

        // Overflow: 66 points, the last two dropped; the last still closes the set
        for (int k = 0; k < 66; k++)
            send_point(t_coord'($urandom), t_coord'($urandom), k == 65, 1'b1);
        start <= 1'b0;
        while (hull_queue.size() != 0) @(posedge i_clk);

        // Random sets; early sets without gaps
        while (fed < 350) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(64) + 1 : $urandom_range(12) + 1;
            mode = $urandom_range(3);
            r = (mode == 0) ? 65535 : (mode == 1 ? 20 : 3);
            for (int k = 0; k < n; k++) begin
                if (mode == 0) begin
                    cx = t_coord'($urandom); cy = t_coord'($urandom);
                end else if (mode == 3) begin
                    cx = t_coord'($urandom_range(6)); cy = cx;  // collinear set
                end else begin
                    cx = t_coord'(int'($urandom_range(2 * r)) - r);
                    cy = t_coord'(int'($urandom_range(2 * r)) - r);
                end
                send_point(cx, cy, k == n - 1, fed > 150);
            end
        end
        start <= 1'b0;
        while (hull_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/cvh_pkg.sv
hw/rtl/cvh_geom.sv
hw/rtl/cvh_dp.sv
hw/rtl/cvh_ctrl.sv
hw/rtl/convex_hull_graham_scan.sv
bench/tb_convex_hull_graham_scan.sv
